@@ sv/scip_pkg.sv @@
// ---------------------------------------------------------------------------
// scip_pkg
// Shared widths, types and the divide step for the segment intersection block.
// ---------------------------------------------------------------------------
package scip_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_BITS   = 24;

    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * DW;
    localparam int CW    = PW + 1;
    localparam int DENW  = CW + 1;
    localparam int MW    = COORD_BITS + CW;
    localparam int NUMW  = MW + 1;
    localparam int NW    = NUMW + FRAC_BITS;
    localparam int QB    = OUT_BITS;
    localparam int HW    = NW - QB;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DW-1:0]         t_diff;
    typedef logic signed [PW-1:0]         t_prod;
    typedef logic signed [CW-1:0]         t_cr;
    typedef logic signed [DENW-1:0]       t_den;
    typedef logic signed [MW-1:0]         t_mul;
    typedef logic signed [NUMW-1:0]       t_num;
    typedef logic signed [NW-1:0]         t_nsc;
    typedef logic signed [OUT_BITS-1:0]   t_out;
    typedef logic [NW-1:0]                t_nmag;
    typedef logic [DENW-1:0]              t_dmag;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_CROSS = 2'd1,
        KIND_TOUCH = 2'd2
    } t_kind;

    localparam logic [1:0] TRI_P [4] = '{2'd0, 2'd0, 2'd2, 2'd2};
    localparam logic [1:0] TRI_Q [4] = '{2'd1, 2'd1, 2'd3, 2'd3};
    localparam logic [1:0] TRI_K [4] = '{2'd2, 2'd3, 2'd0, 2'd1};

    typedef struct packed {
        t_kind kind;
        t_out  tx;
        t_out  ty;
        t_nmag nx_mag;
        logic  nx_neg;
        t_nmag ny_mag;
        logic  ny_neg;
        t_dmag d_mag;
        logic  d_neg;
    } t_item;

    typedef struct packed {
        t_dmag         rem;
        logic [QB-1:0] low;
        logic [QB-1:0] q;
        logic          neg;
        logic          ovf;
    } t_lane;

    typedef struct packed {
        t_kind kind;
        t_out  tx;
        t_out  ty;
        t_dmag d_mag;
        t_lane lx;
        t_lane ly;
    } t_stage;

    function automatic t_lane div_step(t_lane l, t_dmag d);
        logic [DENW:0] t;
        t_lane         r;
        r = l;
        t = {l.rem, l.low[QB-1]};
        r.low = {l.low[QB-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            r.rem = DENW'(t - {1'b0, d});
            r.q   = {l.q[QB-2:0], 1'b1};
        end else begin
            r.rem = DENW'(t);
            r.q   = {l.q[QB-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_lane lane_init(t_nmag n, logic neg, t_dmag d);
        t_lane r;
        r.rem = DENW'(n[NW-1:QB]);
        r.low = n[QB-1:0];
        r.q   = '0;
        r.neg = neg;
        r.ovf = (DENW'(n[NW-1:QB]) >= d);
        return r;
    endfunction

endpackage

@@ sv/scip_front.sv @@
// ---------------------------------------------------------------------------
// scip_front
// Cross products, touch and crossing tests, and numerator forming.
// ---------------------------------------------------------------------------
module scip_front import scip_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_coord i_ax,
    input  t_coord i_ay,
    input  t_coord i_bx,
    input  t_coord i_by,
    input  t_coord i_cx,
    input  t_coord i_cy,
    input  t_coord i_dx,
    input  t_coord i_dy,
    input  logic   i_full,
    output logic   o_push,
    output t_item  o_item
);

    logic   f_en;
    logic   r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    t_coord r_s1_x [4];
    t_coord r_s1_y [4];
    t_coord r_s2_x [4];
    t_coord r_s2_y [4];
    t_prod  r_s2_t1 [4];
    t_prod  r_s2_t2 [4];
    t_prod  n_t1 [4];
    t_prod  n_t2 [4];

    t_kind  r_s3_kind, n_kind;
    t_out   r_s3_tx, r_s3_ty, n_tx, n_ty;
    t_cr    r_s3_cr0, r_s3_cr1;
    t_coord r_s3_cx, r_s3_cy, r_s3_dx, r_s3_dy;
    t_cr    cr [4];

    t_kind  r_s4_kind;
    t_out   r_s4_tx, r_s4_ty;
    t_cr    r_s4_cr0, r_s4_cr1;
    t_mul   r_s4_xc1, r_s4_xd0, r_s4_yc1, r_s4_yd0;

    assign f_en    = !(r_s4_v && i_full);
    assign o_stall = !f_en;
    assign o_push  = r_s4_v && !i_full;

    always_comb begin
        t_diff ex, ey, qx, qy;
        for (int i = 0; i < 4; i++) begin
            ex = t_diff'(r_s1_x[TRI_Q[i]]) - t_diff'(r_s1_x[TRI_P[i]]);
            ey = t_diff'(r_s1_y[TRI_Q[i]]) - t_diff'(r_s1_y[TRI_P[i]]);
            qx = t_diff'(r_s1_x[TRI_K[i]]) - t_diff'(r_s1_x[TRI_P[i]]);
            qy = t_diff'(r_s1_y[TRI_K[i]]) - t_diff'(r_s1_y[TRI_P[i]]);
            n_t1[i] = t_prod'(ex) * t_prod'(qy);
            n_t2[i] = t_prod'(ey) * t_prod'(qx);
        end
    end

    always_comb begin
        logic       found, inbox, opp01, opp23;
        logic [1:0] k;
        t_coord     ix, iy, jx, jy, kx, ky;
        found = 1'b0;
        k     = 2'd0;
        for (int i = 0; i < 4; i++) begin
            cr[i] = t_cr'(r_s2_t1[i]) - t_cr'(r_s2_t2[i]);
            ix = r_s2_x[TRI_P[i]];
            iy = r_s2_y[TRI_P[i]];
            jx = r_s2_x[TRI_Q[i]];
            jy = r_s2_y[TRI_Q[i]];
            kx = r_s2_x[TRI_K[i]];
            ky = r_s2_y[TRI_K[i]];
            inbox = ((ix < jx) ? (ix <= kx && kx <= jx) : (jx <= kx && kx <= ix)) &&
                    ((iy < jy) ? (iy <= ky && ky <= jy) : (jy <= ky && ky <= iy));
            if (!found && cr[i] == '0 && inbox) begin
                found = 1'b1;
                k     = TRI_K[i];
            end
        end
        opp01 = cr[0] != '0 && cr[1] != '0 && (cr[0][CW-1] != cr[1][CW-1]);
        opp23 = cr[2] != '0 && cr[3] != '0 && (cr[2][CW-1] != cr[3][CW-1]);
        n_tx = '0;
        n_ty = '0;
        if (found) begin
            n_kind = KIND_TOUCH;
            n_tx   = t_out'(r_s2_x[k]) <<< FRAC_BITS;
            n_ty   = t_out'(r_s2_y[k]) <<< FRAC_BITS;
        end else if (opp01 && opp23) begin
            n_kind = KIND_CROSS;
        end else begin
            n_kind = KIND_NONE;
        end
    end

    always_comb begin
        t_nsc nx, ny;
        t_den den;
        nx  = t_nsc'(t_num'(r_s4_xc1) - t_num'(r_s4_xd0)) <<< FRAC_BITS;
        ny  = t_nsc'(t_num'(r_s4_yc1) - t_num'(r_s4_yd0)) <<< FRAC_BITS;
        den = t_den'(r_s4_cr1) - t_den'(r_s4_cr0);
        o_item.kind   = r_s4_kind;
        o_item.tx     = r_s4_tx;
        o_item.ty     = r_s4_ty;
        o_item.nx_neg = nx[NW-1];
        o_item.nx_mag = nx[NW-1] ? t_nmag'(-nx) : t_nmag'(nx);
        o_item.ny_neg = ny[NW-1];
        o_item.ny_mag = ny[NW-1] ? t_nmag'(-ny) : t_nmag'(ny);
        o_item.d_neg  = den[DENW-1];
        o_item.d_mag  = den[DENW-1] ? t_dmag'(-den) : t_dmag'(den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (f_en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_s1_x <= '{i_ax, i_bx, i_cx, i_dx};
            r_s1_y <= '{i_ay, i_by, i_cy, i_dy};
            r_s2_x  <= r_s1_x;
            r_s2_y  <= r_s1_y;
            r_s2_t1 <= n_t1;
            r_s2_t2 <= n_t2;
            r_s3_kind <= n_kind;
            r_s3_tx   <= n_tx;
            r_s3_ty   <= n_ty;
            r_s3_cr0  <= cr[0];
            r_s3_cr1  <= cr[1];
            r_s3_cx   <= r_s2_x[2];
            r_s3_cy   <= r_s2_y[2];
            r_s3_dx   <= r_s2_x[3];
            r_s3_dy   <= r_s2_y[3];
            r_s4_kind <= r_s3_kind;
            r_s4_tx   <= r_s3_tx;
            r_s4_ty   <= r_s3_ty;
            r_s4_cr0  <= r_s3_cr0;
            r_s4_cr1  <= r_s3_cr1;
            r_s4_xc1  <= t_mul'(r_s3_cx) * t_mul'(r_s3_cr1);
            r_s4_xd0  <= t_mul'(r_s3_dx) * t_mul'(r_s3_cr0);
            r_s4_yc1  <= t_mul'(r_s3_cy) * t_mul'(r_s3_cr1);
            r_s4_yd0  <= t_mul'(r_s3_dy) * t_mul'(r_s3_cr0);
        end
    end

endmodule

@@ sv/scip_fifo.sv @@
// ---------------------------------------------------------------------------
// scip_fifo
// Short item queue between the classify front and the divide back.
// ---------------------------------------------------------------------------
module scip_fifo import scip_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    t_item                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, r_rp;
    logic [FIFO_AW:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count out of range");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not advance");

endmodule

@@ sv/scip_back.sv @@
// ---------------------------------------------------------------------------
// scip_back
// Pipelined restoring divider for the crossing point and the output register.
// ---------------------------------------------------------------------------
module scip_back import scip_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    input  logic  i_empty,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output t_kind o_kind,
    output t_out  o_px,
    output t_out  o_py
);

    localparam logic [QB-1:0] Q_HALF = QB'(1) << (QB - 1);
    localparam t_out          O_HI   = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam t_out          O_LO   = {1'b1, {(OUT_BITS-1){1'b0}}};

    logic   b_en;
    logic   r_v  [QB+1];
    t_stage r_st [QB+1];
    t_stage n_st [QB+1];
    logic   r_out_v;
    t_kind  r_kind;
    t_out   r_px, r_py;
    t_out   n_px, n_py;

    function automatic t_out lane_out(t_lane l, logic dz);
        t_out r;
        if (dz) begin
            r = '0;
        end else if (l.ovf) begin
            r = l.neg ? O_LO : O_HI;
        end else if (l.neg) begin
            r = (l.q > Q_HALF) ? O_LO : -t_out'(l.q);
        end else begin
            r = (l.q > QB'(O_HI)) ? O_HI : t_out'(l.q);
        end
        return r;
    endfunction

    assign b_en    = !(r_out_v && i_stall);
    assign o_pop   = b_en && !i_empty;
    assign o_valid = r_out_v;
    assign o_kind  = r_kind;
    assign o_px    = r_px;
    assign o_py    = r_py;

    always_comb begin
        n_st[0].kind  = i_item.kind;
        n_st[0].tx    = i_item.tx;
        n_st[0].ty    = i_item.ty;
        n_st[0].d_mag = i_item.d_mag;
        n_st[0].lx    = lane_init(i_item.nx_mag, i_item.nx_neg ^ i_item.d_neg, i_item.d_mag);
        n_st[0].ly    = lane_init(i_item.ny_mag, i_item.ny_neg ^ i_item.d_neg, i_item.d_mag);
        for (int k = 0; k < QB; k++) begin
            n_st[k+1]    = r_st[k];
            n_st[k+1].lx = div_step(r_st[k].lx, r_st[k].d_mag);
            n_st[k+1].ly = div_step(r_st[k].ly, r_st[k].d_mag);
        end
    end

    always_comb begin
        logic dz;
        dz = (r_st[QB].d_mag == '0);
        n_px = '0;
        n_py = '0;
        if (r_st[QB].kind == KIND_TOUCH) begin
            n_px = r_st[QB].tx;
            n_py = r_st[QB].ty;
        end else if (r_st[QB].kind == KIND_CROSS) begin
            n_px = lane_out(r_st[QB].lx, dz);
            n_py = lane_out(r_st[QB].ly, dz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (b_en) begin
            r_v[0] <= o_pop;
            for (int k = 0; k < QB; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_out_v <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_st   <= n_st;
            r_kind <= r_st[QB].kind;
            r_px   <= n_px;
            r_py   <= n_py;
        end
    end

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_kind == KIND_NONE) |-> (r_px == '0 && r_py == '0))
        else $error("no-hit item with nonzero point");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall) |=> (r_out_v && $stable(r_px) && $stable(r_py)))
        else $error("stalled result changed");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_v[0]) else $error("popped item not loaded");

endmodule

@@ sv/segment_intersection_point.sv @@
// ---------------------------------------------------------------------------
// segment_intersection_point
// Exact integer intersection of two segments with fixed-point crossing point.
// ---------------------------------------------------------------------------
// Path from accept to result: 4 front stages, the queue, 25 divider stages
// and the output register.
// Throughput: one item per cycle when not stalled; the divider is fully
// pipelined, one quotient bit per stage for each coordinate.
// Reset: synchronous, active low; clears all valid and queue state.
module segment_intersection_point import scip_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_ax_coord,
    input  logic signed [COORD_BITS-1:0] i_ay_coord,
    input  logic signed [COORD_BITS-1:0] i_bx_coord,
    input  logic signed [COORD_BITS-1:0] i_by_coord,
    input  logic signed [COORD_BITS-1:0] i_cx_coord,
    input  logic signed [COORD_BITS-1:0] i_cy_coord,
    input  logic signed [COORD_BITS-1:0] i_dx_coord,
    input  logic signed [COORD_BITS-1:0] i_dy_coord,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_hit_kind,
    output logic signed [OUT_BITS-1:0] o_px_fixed,
    output logic signed [OUT_BITS-1:0] o_py_fixed
);

    logic  push, pop, full, empty;
    t_item f_item, q_item;
    t_kind kind;

    scip_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_ax    (i_ax_coord),
        .i_ay    (i_ay_coord),
        .i_bx    (i_bx_coord),
        .i_by    (i_by_coord),
        .i_cx    (i_cx_coord),
        .i_cy    (i_cy_coord),
        .i_dx    (i_dx_coord),
        .i_dy    (i_dy_coord),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item)
    );

    scip_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_full  (full),
        .o_empty (empty)
    );

    scip_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (q_item),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_kind  (kind),
        .o_px    (o_px_fixed),
        .o_py    (o_py_fixed)
    );

    assign o_hit_kind = kind;

endmodule
